// ===== rtl/core/bpfs_pkg.sv =====
package bpfs_pkg;

   localparam int FRAC      = 16;
   localparam int SHINE     = 512;
   localparam int EXP_BITS  = 13;
   localparam int POW_STEPS = 2 * EXP_BITS;

   localparam int COL_W  = FRAC + 1;
   localparam int VEC_W  = 34;
   localparam int UNIT_W = FRAC + 2;
   localparam int MAG_W  = 31;
   localparam int ROOT_W = 32;
   localparam int SQ_W   = 64;
   localparam int DR_W   = ROOT_W + FRAC;
   localparam int DOT_W  = 2 * UNIT_W + 2;

   localparam logic [COL_W-1:0] ONE_V  = COL_W'(1) << FRAC;
   localparam logic [FRAC-1:0]  HALF_V = FRAC'(1) << (FRAC - 1);

   localparam int REQ_W = 376;
   localparam int RSP_W = 56;
   localparam int CSR_W = 32;

   typedef enum logic [2:0] {
      CSR_CAMERA_X,
      CSR_CAMERA_Y,
      CSR_CAMERA_Z,
      CSR_INTENSITY_R,
      CSR_INTENSITY_G,
      CSR_INTENSITY_B,
      CSR_HAS_DIFFUSE,
      CSR_HAS_SPECULAR
   } csr_idx_type;

   // positive part of a dot product, shifted down and limited to one
   function automatic logic [COL_W-1:0] dot_clamp(input logic signed [DOT_W-1:0] s);
      logic [DOT_W-1:0] sh;
      begin
         sh = DOT_W'(s >>> FRAC);
         if (s <= 0) dot_clamp = '0;
         else if (sh > DOT_W'(ONE_V)) dot_clamp = ONE_V;
         else dot_clamp = sh[COL_W-1:0];
      end
   endfunction

endpackage

// ===== rtl/core/blinn_phong_fragment_shade_top.sv =====
// throughput: one word per cycle; the whole pipeline advances together and
// holds while a finished result waits on rsp_tready
// the square root and divide stages of the normalizers and the 26 power
// stages set the depth
// reset: synchronous, active high; clears valid bits, camera 0, intensities one, flags 0
module blinn_phong_fragment_shade_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // position_x/y/z, normal_x/y/z, light_dir_x/y/z, attenuation,
   // diffuse_color_packed, specular_weight, zero pad
   input  logic [bpfs_pkg::REQ_W-1:0]    req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // color_red, color_green, color_blue, zero pad
   output logic [bpfs_pkg::RSP_W-1:0]    rsp_tdata,
   input  logic                          csr_we,
   input  logic [2:0]                    csr_index,
   input  logic [bpfs_pkg::CSR_W-1:0]    csr_wdata
);
   import bpfs_pkg::*;

   logic signed [31:0] camera_ff [3];
   logic [23:0]        intens_ff [3];
   logic               has_diff_ff;
   logic               has_spec_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            camera_ff[i] <= '0;
            intens_ff[i] <= 24'(ONE_V);
         end
         has_diff_ff <= 1'b0;
         has_spec_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_idx_type'(csr_index))
            CSR_CAMERA_X:     camera_ff[0] <= csr_wdata;
            CSR_CAMERA_Y:     camera_ff[1] <= csr_wdata;
            CSR_CAMERA_Z:     camera_ff[2] <= csr_wdata;
            CSR_INTENSITY_R:  intens_ff[0] <= csr_wdata[23:0];
            CSR_INTENSITY_G:  intens_ff[1] <= csr_wdata[23:0];
            CSR_INTENSITY_B:  intens_ff[2] <= csr_wdata[23:0];
            CSR_HAS_DIFFUSE:  has_diff_ff  <= csr_wdata[0];
            CSR_HAS_SPECULAR: has_spec_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   logic en;
   logic rsp_vld_ff;
   assign en         = !rsp_vld_ff || rsp_tready;
   assign req_tready = en;

   // input stage
   logic signed [VEC_W-1:0] ld_ff [3];
   logic signed [VEC_W-1:0] nr_ff [3];
   logic signed [VEC_W-1:0] vw_ff [3];
   logic [3*COL_W-1:0]      k_ff;
   logic [FRAC-1:0]         ks_ff;
   logic [COL_W-1:0]        att_ff;
   logic                    i_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) i_vld_ff <= 1'b0;
      else if (en) i_vld_ff <= req_tvalid;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            nr_ff[i] <= VEC_W'($signed(req_tdata[96+32*i +: 32]));
            ld_ff[i] <= VEC_W'($signed(req_tdata[192+32*i +: 32]));
            vw_ff[i] <= VEC_W'(camera_ff[i]) - VEC_W'($signed(req_tdata[32*i +: 32]));
         end
         if (has_diff_ff)
            k_ff <= {1'b0, req_tdata[305+32 +: 16], 1'b0, req_tdata[305+16 +: 16],
                     1'b0, req_tdata[305+0 +: 16]};
         else
            k_ff <= {ONE_V, ONE_V, ONE_V};
         ks_ff  <= has_spec_ff ? req_tdata[353 +: 16] : HALF_V;
         att_ff <= req_tdata[288 +: 17];
      end
   end

   // first normalizers: light, normal, view
   logic signed [UNIT_W-1:0] l_u [3];
   logic signed [UNIT_W-1:0] n_u [3];
   logic signed [UNIT_W-1:0] v_u [3];
   logic [FRAC-1:0]          l_side;
   logic [3*COL_W-1:0]       n_side;
   logic [COL_W-1:0]         v_side;
   logic                     l_vld, n_vld, v_vld;

   bpfs_norm #(.SW(FRAC)) u_norm_l (
      .clock(clock), .reset(reset), .en(en), .in_valid(i_vld_ff),
      .in_x(ld_ff[0]), .in_y(ld_ff[1]), .in_z(ld_ff[2]), .in_side(ks_ff),
      .out_valid(l_vld), .out_x(l_u[0]), .out_y(l_u[1]), .out_z(l_u[2]),
      .out_side(l_side));

   bpfs_norm #(.SW(3*COL_W)) u_norm_n (
      .clock(clock), .reset(reset), .en(en), .in_valid(i_vld_ff),
      .in_x(nr_ff[0]), .in_y(nr_ff[1]), .in_z(nr_ff[2]), .in_side(k_ff),
      .out_valid(n_vld), .out_x(n_u[0]), .out_y(n_u[1]), .out_z(n_u[2]),
      .out_side(n_side));

   bpfs_norm #(.SW(COL_W)) u_norm_v (
      .clock(clock), .reset(reset), .en(en), .in_valid(i_vld_ff),
      .in_x(vw_ff[0]), .in_y(vw_ff[1]), .in_z(vw_ff[2]), .in_side(att_ff),
      .out_valid(v_vld), .out_x(v_u[0]), .out_y(v_u[1]), .out_z(v_u[2]),
      .out_side(v_side));

   // half vector and lambert dot
   logic signed [UNIT_W:0]     h1_half_ff [3];
   logic signed [2*UNIT_W-1:0] h1_prod_ff [3];
   logic signed [UNIT_W-1:0]   h1_n_ff [3];
   logic [3*COL_W-1:0]         h1_k_ff;
   logic [FRAC-1:0]            h1_ks_ff;
   logic [COL_W-1:0]           h1_att_ff;
   logic                       h1_vld_ff;

   logic signed [UNIT_W:0]     h2_half_ff [3];
   logic [COL_W-1:0]           h2_ang_ff;
   logic signed [UNIT_W-1:0]   h2_n_ff [3];
   logic [3*COL_W-1:0]         h2_k_ff;
   logic [FRAC-1:0]            h2_ks_ff;
   logic [COL_W-1:0]           h2_att_ff;
   logic                       h2_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         h1_vld_ff <= 1'b0;
         h2_vld_ff <= 1'b0;
      end else if (en) begin
         h1_vld_ff <= l_vld & n_vld & v_vld;
         h2_vld_ff <= h1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            h1_half_ff[i] <= (UNIT_W+1)'(v_u[i]) + (UNIT_W+1)'(l_u[i]);
            h1_prod_ff[i] <= (2*UNIT_W)'(l_u[i]) * (2*UNIT_W)'(n_u[i]);
            h1_n_ff[i]    <= n_u[i];
            h2_half_ff[i] <= h1_half_ff[i];
            h2_n_ff[i]    <= h1_n_ff[i];
         end
         h1_k_ff   <= n_side;
         h1_ks_ff  <= l_side;
         h1_att_ff <= v_side;
         h2_ang_ff <= dot_clamp(DOT_W'(h1_prod_ff[0]) + DOT_W'(h1_prod_ff[1])
                                + DOT_W'(h1_prod_ff[2]));
         h2_k_ff   <= h1_k_ff;
         h2_ks_ff  <= h1_ks_ff;
         h2_att_ff <= h1_att_ff;
      end
   end

   // second normalizer: half vector
   localparam int S2_W = 3*UNIT_W + COL_W + 3*COL_W + FRAC + COL_W;

   logic signed [UNIT_W-1:0] hv_u [3];
   logic [S2_W-1:0]          s2_out;
   logic                     s2_vld;

   bpfs_norm #(.SW(S2_W)) u_norm_h (
      .clock(clock), .reset(reset), .en(en), .in_valid(h2_vld_ff),
      .in_x(VEC_W'(h2_half_ff[0])), .in_y(VEC_W'(h2_half_ff[1])),
      .in_z(VEC_W'(h2_half_ff[2])),
      .in_side({h2_n_ff[2], h2_n_ff[1], h2_n_ff[0], h2_ang_ff, h2_k_ff, h2_ks_ff,
                h2_att_ff}),
      .out_valid(s2_vld), .out_x(hv_u[0]), .out_y(hv_u[1]), .out_z(hv_u[2]),
      .out_side(s2_out));

   logic signed [UNIT_W-1:0] s2_n [3];
   logic [COL_W-1:0]         s2_ang;
   logic [COL_W-1:0]         s2_k [3];
   logic [FRAC-1:0]          s2_ks;
   logic [COL_W-1:0]         s2_att;

   assign s2_att  = s2_out[0 +: COL_W];
   assign s2_ks   = s2_out[COL_W +: FRAC];
   assign s2_k[2] = s2_out[COL_W+FRAC +: COL_W];
   assign s2_k[1] = s2_out[2*COL_W+FRAC +: COL_W];
   assign s2_k[0] = s2_out[3*COL_W+FRAC +: COL_W];
   assign s2_ang  = s2_out[4*COL_W+FRAC +: COL_W];
   assign s2_n[0] = s2_out[5*COL_W+FRAC +: UNIT_W];
   assign s2_n[1] = s2_out[5*COL_W+FRAC+UNIT_W +: UNIT_W];
   assign s2_n[2] = s2_out[5*COL_W+FRAC+2*UNIT_W +: UNIT_W];

   // specular dot and diffuse chain
   logic signed [2*UNIT_W-1:0] p1_prod_ff [3];
   logic [COL_W-1:0]           p1_d_ff [3];
   logic [FRAC-1:0]            p1_ks_ff;
   logic [COL_W-1:0]           p1_att_ff;
   logic                       p1_vld_ff;

   logic [COL_W-1:0]           p2_nh_ff;
   logic [24:0]                p2_d_ff [3];
   logic [FRAC-1:0]            p2_ks_ff;
   logic [COL_W-1:0]           p2_att_ff;
   logic                       p2_vld_ff;

   logic [COL_W-1:0]           pw_r_ff  [POW_STEPS+1];
   logic [COL_W-1:0]           pw_x_ff  [POW_STEPS+1];
   logic [25:0]                pw_d_ff  [POW_STEPS+1][3];
   logic [FRAC-1:0]            pw_ks_ff [POW_STEPS+1];
   logic                       pw_vld_ff [POW_STEPS+1];

   logic [2*COL_W-1:0] p1_mul [3];
   logic [40:0]        p2_mul [3];
   logic [41:0]        p3_mul [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         p1_mul[i] = (2*COL_W)'(s2_k[i]) * (2*COL_W)'(s2_ang);
         p2_mul[i] = 41'(p1_d_ff[i]) * 41'(intens_ff[i]);
         p3_mul[i] = 42'(p2_d_ff[i]) * 42'(p2_att_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_vld_ff    <= 1'b0;
         p2_vld_ff    <= 1'b0;
         pw_vld_ff[0] <= 1'b0;
      end else if (en) begin
         p1_vld_ff    <= s2_vld;
         p2_vld_ff    <= p1_vld_ff;
         pw_vld_ff[0] <= p2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            p1_prod_ff[i] <= (2*UNIT_W)'(s2_n[i]) * (2*UNIT_W)'(hv_u[i]);
            p1_d_ff[i]    <= p1_mul[i][FRAC +: COL_W];
            p2_d_ff[i]    <= p2_mul[i][40:FRAC];
            pw_d_ff[0][i] <= p3_mul[i][41:FRAC];
         end
         p1_ks_ff  <= s2_ks;
         p1_att_ff <= s2_att;
         p2_nh_ff  <= dot_clamp(DOT_W'(p1_prod_ff[0]) + DOT_W'(p1_prod_ff[1])
                                + DOT_W'(p1_prod_ff[2]));
         p2_ks_ff  <= p1_ks_ff;
         p2_att_ff <= p1_att_ff;
         pw_r_ff[0]  <= ONE_V;
         pw_x_ff[0]  <= p2_nh_ff;
         pw_ks_ff[0] <= p2_ks_ff;
      end
   end

   // power by msb-first square and multiply, at most one multiply per stage
   for (genvar j = 0; j < POW_STEPS; j++) begin : g_pow
      localparam int B = EXP_BITS - 1 - j / 2;
      logic [2*COL_W-1:0] prod;
      logic [COL_W-1:0]   r_in;

      if (j % 2 == 0) begin : g_sq
         assign prod = (2*COL_W)'(pw_r_ff[j]) * (2*COL_W)'(pw_r_ff[j]);
         assign r_in = prod[FRAC +: COL_W];
      end else if (((SHINE >> B) & 1) != 0) begin : g_mul
         assign prod = (2*COL_W)'(pw_r_ff[j]) * (2*COL_W)'(pw_x_ff[j]);
         assign r_in = prod[FRAC +: COL_W];
      end else begin : g_pass
         assign prod = '0;
         assign r_in = pw_r_ff[j] | prod[COL_W-1:0];
      end

      always_ff @(posedge clock) begin
         if (reset) pw_vld_ff[j+1] <= 1'b0;
         else if (en) pw_vld_ff[j+1] <= pw_vld_ff[j];
      end

      always_ff @(posedge clock) begin
         if (en) begin
            pw_r_ff[j+1]  <= r_in;
            pw_x_ff[j+1]  <= pw_x_ff[j];
            pw_d_ff[j+1]  <= pw_d_ff[j];
            pw_ks_ff[j+1] <= pw_ks_ff[j];
         end
      end
   end

   // specular weight, then sum and clamp
   logic [FRAC+COL_W-1:0] s1_mul;
   logic [COL_W-1:0]      s1_spec_ff;
   logic [25:0]           s1_d_ff [3];
   logic                  s1_vld_ff;
   logic [26:0]           sum_c [3];
   logic [COL_W-1:0]      col_c [3];
   logic [RSP_W-1:0]      rsp_data_ff;

   assign s1_mul = (FRAC+COL_W)'(pw_ks_ff[POW_STEPS]) * (FRAC+COL_W)'(pw_r_ff[POW_STEPS]);

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sum_c[i] = 27'(s1_d_ff[i]) + 27'(s1_spec_ff);
         col_c[i] = (sum_c[i] > 27'(ONE_V)) ? ONE_V : sum_c[i][COL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else if (en) begin
         s1_vld_ff  <= pw_vld_ff[POW_STEPS];
         rsp_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_spec_ff  <= s1_mul[FRAC +: COL_W];
         s1_d_ff     <= pw_d_ff[POW_STEPS];
         rsp_data_ff <= {{(RSP_W-3*COL_W){1'b0}}, col_c[2], col_c[1], col_c[0]};
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef ASSERT_OFF
   a_color_red_max: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[COL_W-1:0] <= ONE_V)
      else $error("red above one");
   a_color_blue_max: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[3*COL_W-1:2*COL_W] <= ONE_V)
      else $error("blue above one");
   a_pow_max: assert property (@(posedge clock) disable iff (reset)
      pw_vld_ff[POW_STEPS] |-> pw_r_ff[POW_STEPS] <= ONE_V)
      else $error("power result above one");
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");
`endif

endmodule

// ===== rtl/core/bpfs_norm.sv =====
module bpfs_norm #(
   parameter int SW = 1
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 en,
   input  logic                                 in_valid,
   input  logic signed [bpfs_pkg::VEC_W-1:0]    in_x,
   input  logic signed [bpfs_pkg::VEC_W-1:0]    in_y,
   input  logic signed [bpfs_pkg::VEC_W-1:0]    in_z,
   input  logic [SW-1:0]                        in_side,
   output logic                                 out_valid,
   output logic signed [bpfs_pkg::UNIT_W-1:0]   out_x,
   output logic signed [bpfs_pkg::UNIT_W-1:0]   out_y,
   output logic signed [bpfs_pkg::UNIT_W-1:0]   out_z,
   output logic [SW-1:0]                        out_side
);
   import bpfs_pkg::*;

   localparam int SQ_STEPS = ROOT_W;
   localparam int DV_STEPS = FRAC + 1;
   localparam int CW       = 3 + 3 * MAG_W + SW;

   logic signed [VEC_W-1:0] vin [3];
   logic [VEC_W-2:0]        abs_v [3];
   logic                    wide;
   logic [MAG_W-1:0]        a_mag_in [3];

   logic [MAG_W-1:0]   a_mag_ff [3];
   logic [2:0]         a_sgn_ff;
   logic [SW-1:0]      a_side_ff;
   logic               a_vld_ff;

   logic [2*MAG_W-1:0] b_sq_ff [3];
   logic [MAG_W-1:0]   b_mag_ff [3];
   logic [2:0]         b_sgn_ff;
   logic [SW-1:0]      b_side_ff;
   logic               b_vld_ff;

   logic [SQ_W-1:0]    sq_rem_ff  [SQ_STEPS+1];
   logic [ROOT_W-1:0]  sq_root_ff [SQ_STEPS+1];
   logic [CW-1:0]      sq_car_ff  [SQ_STEPS+1];
   logic               sq_vld_ff  [SQ_STEPS+1];

   logic [DR_W-1:0]    dv_rem_ff [DV_STEPS+1][3];
   logic [COL_W-1:0]   dv_q_ff   [DV_STEPS+1][3];
   logic [ROOT_W-1:0]  dv_len_ff [DV_STEPS+1];
   logic [2+SW:0]      dv_car_ff [DV_STEPS+1];
   logic               dv_vld_ff [DV_STEPS+1];

   logic [MAG_W-1:0]   fin_mag [3];

   assign vin[0] = in_x;
   assign vin[1] = in_y;
   assign vin[2] = in_z;

   // halve everything when any component needs 32 magnitude bits
   always_comb begin
      for (int i = 0; i < 3; i++)
         abs_v[i] = vin[i][VEC_W-1] ? (VEC_W-1)'(-vin[i]) : (VEC_W-1)'(vin[i]);
      wide = (|abs_v[0][VEC_W-2:MAG_W]) | (|abs_v[1][VEC_W-2:MAG_W])
           | (|abs_v[2][VEC_W-2:MAG_W]);
      for (int i = 0; i < 3; i++)
         a_mag_in[i] = wide ? abs_v[i][MAG_W:1] : abs_v[i][MAG_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
         sq_vld_ff[0] <= 1'b0;
      end else if (en) begin
         a_vld_ff <= in_valid;
         b_vld_ff <= a_vld_ff;
         sq_vld_ff[0] <= b_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            a_mag_ff[i] <= a_mag_in[i];
            b_sq_ff[i]  <= (2*MAG_W)'(a_mag_ff[i]) * (2*MAG_W)'(a_mag_ff[i]);
            b_mag_ff[i] <= a_mag_ff[i];
         end
         a_sgn_ff  <= {vin[2][VEC_W-1], vin[1][VEC_W-1], vin[0][VEC_W-1]};
         a_side_ff <= in_side;
         b_sgn_ff  <= a_sgn_ff;
         b_side_ff <= a_side_ff;
         sq_rem_ff[0]  <= SQ_W'(b_sq_ff[0]) + SQ_W'(b_sq_ff[1]) + SQ_W'(b_sq_ff[2]);
         sq_root_ff[0] <= '0;
         sq_car_ff[0]  <= {b_sgn_ff, b_mag_ff[2], b_mag_ff[1], b_mag_ff[0], b_side_ff};
      end
   end

   // square root, one result bit per stage
   for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
      localparam int B = SQ_STEPS - 1 - k;
      logic [SQ_W+1:0]   trial;
      logic [SQ_W-1:0]   rem_in;
      logic [ROOT_W-1:0] root_in;

      always_comb begin
         trial = ((SQ_W+2)'(sq_root_ff[k]) << (B + 1)) + ((SQ_W+2)'(1) << (2 * B));
         if ((SQ_W+2)'(sq_rem_ff[k]) >= trial) begin
            rem_in  = SQ_W'((SQ_W+2)'(sq_rem_ff[k]) - trial);
            root_in = sq_root_ff[k] | (ROOT_W'(1) << B);
         end else begin
            rem_in  = sq_rem_ff[k];
            root_in = sq_root_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) sq_vld_ff[k+1] <= 1'b0;
         else if (en) sq_vld_ff[k+1] <= sq_vld_ff[k];
      end

      always_ff @(posedge clock) begin
         if (en) begin
            sq_rem_ff[k+1]  <= rem_in;
            sq_root_ff[k+1] <= root_in;
            sq_car_ff[k+1]  <= sq_car_ff[k];
         end
      end
   end

   assign fin_mag[0] = sq_car_ff[SQ_STEPS][SW +: MAG_W];
   assign fin_mag[1] = sq_car_ff[SQ_STEPS][SW+MAG_W +: MAG_W];
   assign fin_mag[2] = sq_car_ff[SQ_STEPS][SW+2*MAG_W +: MAG_W];

   always_ff @(posedge clock) begin
      if (reset) dv_vld_ff[0] <= 1'b0;
      else if (en) dv_vld_ff[0] <= sq_vld_ff[SQ_STEPS];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            dv_rem_ff[0][i] <= DR_W'({fin_mag[i], {FRAC{1'b0}}});
            dv_q_ff[0][i]   <= '0;
         end
         dv_len_ff[0] <= sq_root_ff[SQ_STEPS];
         dv_car_ff[0] <= {sq_car_ff[SQ_STEPS][CW-1 -: 3], sq_car_ff[SQ_STEPS][SW-1:0]};
      end
   end

   // restoring divide of magnitude by length, quotient never exceeds one
   for (genvar j = 0; j < DV_STEPS; j++) begin : g_div
      localparam int K = DV_STEPS - 1 - j;
      logic [DR_W-1:0]  trial;
      logic [DR_W-1:0]  rem_in [3];
      logic [COL_W-1:0] q_in   [3];

      always_comb begin
         trial = DR_W'(dv_len_ff[j]) << K;
         for (int i = 0; i < 3; i++) begin
            if (dv_rem_ff[j][i] >= trial) begin
               rem_in[i] = dv_rem_ff[j][i] - trial;
               q_in[i]   = dv_q_ff[j][i] | (COL_W'(1) << K);
            end else begin
               rem_in[i] = dv_rem_ff[j][i];
               q_in[i]   = dv_q_ff[j][i];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) dv_vld_ff[j+1] <= 1'b0;
         else if (en) dv_vld_ff[j+1] <= dv_vld_ff[j];
      end

      always_ff @(posedge clock) begin
         if (en) begin
            for (int i = 0; i < 3; i++) begin
               dv_rem_ff[j+1][i] <= rem_in[i];
               dv_q_ff[j+1][i]   <= q_in[i];
            end
            dv_len_ff[j+1] <= dv_len_ff[j];
            dv_car_ff[j+1] <= dv_car_ff[j];
         end
      end
   end

   logic signed [UNIT_W-1:0] u_in [3];
   logic signed [UNIT_W-1:0] u_ff [3];
   logic [SW-1:0]            side_ff;
   logic                     vld_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (dv_len_ff[DV_STEPS] == '0) u_in[i] = '0;
         else if (dv_car_ff[DV_STEPS][SW+i])
            u_in[i] = -$signed({1'b0, dv_q_ff[DV_STEPS][i]});
         else
            u_in[i] = $signed({1'b0, dv_q_ff[DV_STEPS][i]});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= 1'b0;
      else if (en) vld_ff <= dv_vld_ff[DV_STEPS];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) u_ff[i] <= u_in[i];
         side_ff <= dv_car_ff[DV_STEPS][SW-1:0];
      end
   end

   assign out_valid = vld_ff;
   assign out_x     = u_ff[0];
   assign out_y     = u_ff[1];
   assign out_z     = u_ff[2];
   assign out_side  = side_ff;

endmodule

// ===== bench/tb_blinn_phong_fragment_shade_top.sv =====
`timescale 1ns / 1ps

module tb_blinn_phong_fragment_shade_top;
   import bpfs_pkg::*;

   localparam int LATENCY     = 142;
   localparam int CYCLE_LIMIT = 400000;
   localparam int N_RANDOM    = 1300;

   typedef struct packed {
      logic [16:0] blue;
      logic [16:0] green;
      logic [16:0] red;
   } color_t;

   typedef struct {
      logic signed [31:0] pos[3];
      logic signed [31:0] nrm[3];
      logic signed [31:0] ldir[3];
      logic [16:0]        atten;
      logic [47:0]        diffuse;
      logic [15:0]        ks;
   } fragment_t;

   logic clock, reset;
   logic req_tvalid, req_tready;
   logic [REQ_W-1:0] req_tdata;
   logic rsp_tvalid, rsp_tready;
   logic [RSP_W-1:0] rsp_tdata;
   logic csr_we;
   logic [2:0] csr_index;
   logic [CSR_W-1:0] csr_wdata;

   blinn_phong_fragment_shade_top u_top (.*);

   // shadow copy of the frame settings
   logic signed [31:0] cam[3];
   logic [23:0] intensity[3];
   logic diffuse_on, specular_on;

   color_t expected_colors[$];
   int errors = 0;
   int checked = 0;
   longint cycle_count = 0;
   bit hold_off = 0;
   bit quiet_phase = 0;

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("blinn_phong_fragment_shade_top test failed");
         $finish;
      end
   end

   function automatic longint abs64(longint v);
      return v < 0 ? -v : v;
   endfunction

   function automatic longint int_sqrt(longint unsigned s);
      longint unsigned root, bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > s) bitv >>= 2;
      while (bitv != 0) begin
         if (s >= root + bitv) begin
            s -= root + bitv;
            root = (root >> 1) + bitv;
         end else begin
            root >>= 1;
         end
         bitv >>= 2;
      end
      return root;
   endfunction

   function automatic void unit_vector(input longint v[3], output longint u[3]);
      longint c[3];
      longint unsigned s, m;
      longint len;
      bit wide;
      wide = 0;
      s = 0;
      foreach (v[i]) if (abs64(v[i]) >= (64'sd1 << 31)) wide = 1;
      foreach (v[i]) c[i] = wide ? v[i] / 2 : v[i];
      foreach (c[i]) begin
         m = abs64(c[i]);
         s += m * m;
      end
      len = int_sqrt(s);
      foreach (c[i]) u[i] = (len == 0) ? 0 : (c[i] * 65536) / len;
   endfunction

   function automatic longint clamped_dot(longint a[3], longint b[3]);
      longint s;
      s = a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
      if (s <= 0) return 0;
      s = s >>> FRAC;
      return s > 65536 ? 65536 : s;
   endfunction

   function automatic color_t shade_fragment(fragment_t f);
      longint ldir[3], nrm[3], view[3], half_v[3];
      longint l[3], n[3], vd[3], h[3];
      longint unsigned angle, nh, r, ks, spec, k, d, c;
      longint unsigned kd[3], ch[3];
      color_t o;
      foreach (ldir[i]) begin
         ldir[i] = f.ldir[i];
         nrm[i]  = f.nrm[i];
         view[i] = longint'(cam[i]) - longint'(f.pos[i]);
      end
      unit_vector(ldir, l);
      unit_vector(nrm, n);
      angle = clamped_dot(l, n);
      unit_vector(view, vd);
      foreach (half_v[i]) half_v[i] = vd[i] + l[i];
      unit_vector(half_v, h);
      nh = clamped_dot(n, h);
      r = 65536;
      for (int b = 12; b >= 0; b--) begin
         r = (r * r) >> FRAC;
         if (((SHINE >> b) & 1) != 0) r = (r * nh) >> FRAC;
      end
      ks = specular_on ? f.ks : 32768;
      spec = (ks * r) >> FRAC;
      kd[0] = 64'(f.diffuse[47:32]);
      kd[1] = 64'(f.diffuse[31:16]);
      kd[2] = 64'(f.diffuse[15:0]);
      foreach (ch[i]) begin
         k = diffuse_on ? kd[i] : 65536;
         d = (k * angle) >> FRAC;
         d = (d * intensity[i]) >> FRAC;
         d = (d * f.atten) >> FRAC;
         c = d + spec;
         ch[i] = c > 65536 ? 65536 : c;
      end
      o.red = 17'(ch[0]);
      o.green = 17'(ch[1]);
      o.blue = 17'(ch[2]);
      return o;
   endfunction

   function automatic logic [REQ_W-1:0] pack_fragment(fragment_t f);
      logic [REQ_W-1:0] w;
      w = '0;
      for (int i = 0; i < 3; i++) begin
         w[32*i +: 32]       = f.pos[i];
         w[96 + 32*i +: 32]  = f.nrm[i];
         w[192 + 32*i +: 32] = f.ldir[i];
      end
      w[288 +: 17] = f.atten;
      w[305 +: 48] = f.diffuse;
      w[353 +: 16] = f.ks;
      return w;
   endfunction

   task automatic write_csr(csr_idx_type idx, logic [31:0] value);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 0;
      case (idx)
         CSR_CAMERA_X, CSR_CAMERA_Y, CSR_CAMERA_Z: cam[idx] = value;
         CSR_INTENSITY_R, CSR_INTENSITY_G, CSR_INTENSITY_B: intensity[idx - 3] = value[23:0];
         CSR_HAS_DIFFUSE: diffuse_on = value[0];
         CSR_HAS_SPECULAR: specular_on = value[0];
         default: ;
      endcase
   endtask

   task automatic send_fragment(fragment_t f, bit exact, color_t known);
      while (!quiet_phase && $urandom_range(99) < 16) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= pack_fragment(f);
      expected_colors.push_back(exact ? known : shade_fragment(f));
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic drain;
      req_tvalid <= 0;
      while (expected_colors.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   function automatic logic signed [31:0] rand_coord(int mode);
      case (mode)
         0: return $urandom;
         1: return $signed($urandom_range(0, 20 << 16)) - (10 << 16);
         default: return $signed($urandom_range(0, 512)) - 256;
      endcase
   endfunction

   function automatic fragment_t rand_fragment();
      fragment_t f;
      int mode;
      mode = $urandom_range(9) == 0 ? 0 : ($urandom_range(7) == 0 ? 2 : 1);
      foreach (f.pos[i]) begin
         f.pos[i]  = rand_coord(mode);
         f.nrm[i]  = rand_coord(mode);
         f.ldir[i] = rand_coord(mode);
      end
      if ($urandom_range(15) == 0) f.nrm = '{0, 0, 0};
      f.atten   = $urandom_range(3) == 0 ? 17'd65536 : $urandom_range(0, 65536);
      if ($urandom_range(15) == 0) f.atten = $urandom_range(65537, 131071);
      f.diffuse = {$urandom, $urandom};
      f.ks      = $urandom;
      return f;
   endfunction

   // receiver: random stalls plus one long hold-off
   initial begin
      rsp_tready = 0;
      @(negedge reset);
      forever begin
         if (hold_off) begin
            rsp_tready <= 0;
            repeat (400) @(posedge clock);
            hold_off = 0;
         end
         rsp_tready <= quiet_phase || ($urandom_range(99) >= 16);
         @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         color_t got, exp_c;
         got = rsp_tdata[50:0];
         if (expected_colors.size() == 0) begin
            $error("unexpected result word %h", rsp_tdata);
            errors++;
         end else begin
            exp_c = expected_colors.pop_front();
            checked++;
            if (got.red !== exp_c.red) begin
               $error("color_red expected %0d got %0d", exp_c.red, got.red);
               errors++;
            end
            if (got.green !== exp_c.green) begin
               $error("color_green expected %0d got %0d", exp_c.green, got.green);
               errors++;
            end
            if (got.blue !== exp_c.blue) begin
               $error("color_blue expected %0d got %0d", exp_c.blue, got.blue);
               errors++;
            end
         end
      end
   end

   initial begin
      fragment_t table_rows[$];
      bit row_known[$];
      color_t row_color[$];
      fragment_t f;
      color_t zero_c, half_c, one_c;
      logic signed [31:0] max_s, min_s;
      max_s = 32'sh7FFFFFFF;
      min_s = 32'sh80000000;
      zero_c = '0;
      half_c = '{17'd32768, 17'd32768, 17'd32768};
      one_c = '{17'd65536, 17'd65536, 17'd65536};
      cam = '{0, 0, 0};
      intensity = '{24'd65536, 24'd65536, 24'd65536};
      diffuse_on = 0;
      specular_on = 0;
      reset = 1;
      req_tvalid = 0;
      req_tdata = '0;
      csr_we = 0;
      csr_index = CSR_CAMERA_X;
      csr_wdata = '0;
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed rows; base: normal, light and view all along +z
      f.pos = '{0, 0, -65536};
      f.nrm = '{0, 0, 65536};
      f.ldir = '{0, 0, 65536};
      f.atten = 65536;
      f.diffuse = '0;
      f.ks = 0;
      // head-on after reset: full diffuse plus half specular, clamped to one
      table_rows.push_back(f); row_known.push_back(1); row_color.push_back(one_c);
      // zero attenuation leaves only the default specular
      f.atten = 0;
      table_rows.push_back(f); row_known.push_back(1); row_color.push_back(half_c);
      // zero-length normal gives black
      f.nrm = '{0, 0, 0};
      f.atten = 65536;
      table_rows.push_back(f); row_known.push_back(1); row_color.push_back(zero_c);
      // zero-length light direction
      f.nrm = '{0, 0, 65536};
      f.ldir = '{0, 0, 0};
      table_rows.push_back(f); row_known.push_back(0); row_color.push_back(zero_c);
      // light behind the surface
      f.ldir = '{0, 0, -65536};
      table_rows.push_back(f); row_known.push_back(0); row_color.push_back(zero_c);
      // field extremes and a wide view vector
      f.pos = '{max_s, min_s, max_s};
      f.nrm = '{min_s, max_s, min_s};
      f.ldir = '{max_s, max_s, min_s};
      f.atten = 17'h1FFFF;
      f.diffuse = '1;
      f.ks = '1;
      table_rows.push_back(f); row_known.push_back(0); row_color.push_back(zero_c);
      f.pos = '{min_s, min_s, min_s};
      f.nrm = '{max_s, max_s, max_s};
      f.ldir = '{1, -1, 1};
      f.atten = 1;
      table_rows.push_back(f); row_known.push_back(0); row_color.push_back(zero_c);
      f.pos = '{0, 0, 0};
      f.nrm = '{0, 65536, 0};
      f.ldir = '{0, 65536, 0};
      f.atten = 65537;
      f.diffuse = 48'h8000_4000_2000;
      table_rows.push_back(f); row_known.push_back(0); row_color.push_back(zero_c);
      foreach (table_rows[i]) send_fragment(table_rows[i], row_known[i], row_color[i]);
      drain();

      // several settings, extremes included; random fragments under each
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin
               write_csr(CSR_HAS_DIFFUSE, 1);
               write_csr(CSR_HAS_SPECULAR, 1);
            end
            1: begin
               write_csr(CSR_CAMERA_X, 32'h7FFFFFFF);
               write_csr(CSR_CAMERA_Y, 32'h80000000);
               write_csr(CSR_CAMERA_Z, 32'h00050000);
               write_csr(CSR_INTENSITY_R, 24'hFFFFFF);
               write_csr(CSR_INTENSITY_G, 0);
               write_csr(CSR_INTENSITY_B, 24'h008000);
            end
            2: begin
               write_csr(CSR_HAS_DIFFUSE, 0);
               write_csr(CSR_CAMERA_X, 32'h80000000);
               write_csr(CSR_CAMERA_Y, 32'h7FFFFFFF);
               write_csr(CSR_CAMERA_Z, 32'h80000000);
               hold_off = 1;
            end
            3: begin
               write_csr(CSR_HAS_SPECULAR, 0);
               write_csr(CSR_HAS_DIFFUSE, 1);
               write_csr(CSR_CAMERA_X, $urandom_range(0, 10 << 16) - (5 << 16));
               write_csr(CSR_CAMERA_Y, $urandom_range(0, 10 << 16) - (5 << 16));
               write_csr(CSR_CAMERA_Z, 20 << 16);
               write_csr(CSR_INTENSITY_R, $urandom_range(0, 1 << 18));
               write_csr(CSR_INTENSITY_G, $urandom_range(0, 1 << 18));
               write_csr(CSR_INTENSITY_B, $urandom_range(0, 1 << 18));
               quiet_phase = 1;
            end
            4: begin
               quiet_phase = 0;
               write_csr(CSR_HAS_SPECULAR, 1);
               write_csr(CSR_CAMERA_X, 0);
               write_csr(CSR_CAMERA_Y, 0);
               write_csr(CSR_CAMERA_Z, 0);
            end
            default: begin
               write_csr(CSR_INTENSITY_R, 24'd65536);
               write_csr(CSR_INTENSITY_G, 24'd65536);
               write_csr(CSR_INTENSITY_B, 24'd65536);
            end
         endcase
         for (int i = 0; i < N_RANDOM / 6; i++) send_fragment(rand_fragment(), 0, zero_c);
         drain();
      end

      $display("checked %0d result words over the directed rows and six register settings",
               checked);
      if (errors == 0) begin
         $display("blinn_phong_fragment_shade_top test passed");
      end else begin
         $display("blinn_phong_fragment_shade_top test failed");
      end
      $finish;
   end

endmodule
